FILE: design/psoi_pkg.sv
// Package: sequencer state type and fixed constants for the prime interval summer.
`default_nettype none
package psoi_pkg;

  localparam int unsigned IN_W    = 17;
  localparam int unsigned TOTAL_W = 29;
  localparam int unsigned PRIME_W = 16;
  localparam int unsigned BIT_W   = 4;

  localparam logic [PRIME_W-1:0] FIRST_PRIME = 16'd2;
  localparam logic [IN_W-1:0]    FIRST_ODD   = 17'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_CAND,
    ST_RD,
    ST_WAIT,
    ST_CMP,
    ST_DIV,
    ST_DIVEND,
    ST_STORE,
    ST_SRD,
    ST_SWAIT,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: design/prime_sum_over_interval.sv
// Top level: prime table builder by trial division and interval summer.
// One transaction builds the prime table by trial division, each division being a table read,
// a square and a 16-step bit-serial remainder, with a square check that can end a candidate's
// search, and then sums the table entries in the interval. The single-port table memory and
// shared remainder unit set this pace; one query at a time.
// Reset clears control state; the table memory is left undefined and rebuilt per query.
`default_nettype none
module prime_sum_over_interval #(
  parameter int unsigned MAX_BOUND   = 65535,
  parameter int unsigned TABLE_DEPTH = 8192
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [psoi_pkg::IN_W-1:0]    in_range_low,
  input  wire logic signed [psoi_pkg::IN_W-1:0]    in_range_high,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [psoi_pkg::TOTAL_W-1:0]             out_prime_total
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic signed [psoi_pkg::IN_W-1:0] MAX_HI = psoi_pkg::IN_W'(MAX_BOUND);
  localparam logic signed [psoi_pkg::IN_W-1:0] MIN_TOP = psoi_pkg::FIRST_ODD;

  psoi_pkg::state_t state_r, state_nxt;

  logic [psoi_pkg::PRIME_W-1:0]       mem [TABLE_DEPTH];
  logic [psoi_pkg::PRIME_W-1:0]       rd_data_r;
  logic                               rd_en;
  logic [AW-1:0]                      rd_addr;
  logic                               wr_en;
  logic [AW-1:0]                      wr_addr;
  logic [psoi_pkg::PRIME_W-1:0]       wr_data;

  logic signed [psoi_pkg::IN_W-1:0]   lo_r;
  logic signed [psoi_pkg::IN_W-1:0]   hi_r;
  logic [psoi_pkg::IN_W-1:0]          cand_r;
  logic [CW-1:0]                      count_r;
  logic [CW-1:0]                      k_r;
  logic [psoi_pkg::PRIME_W-1:0]       p_r;
  logic [2*psoi_pkg::PRIME_W-1:0]     sq_r;
  logic [psoi_pkg::PRIME_W-1:0]       rem_r;
  logic [psoi_pkg::BIT_W-1:0]         bit_r;
  logic [psoi_pkg::TOTAL_W-1:0]       sum_r;
  logic                               out_valid_r;
  logic [psoi_pkg::TOTAL_W-1:0]       out_total_r;

  logic                               cand_go;
  logic [psoi_pkg::PRIME_W:0]         rem_shift;
  logic [psoi_pkg::PRIME_W:0]         rem_diff;
  logic                               rem_ge;
  logic                               p_above_hi;
  logic                               p_below_lo;
  logic                               out_free;

  assign cand_go = (hi_r >= MIN_TOP) && (cand_r <= {1'b0, hi_r[psoi_pkg::PRIME_W-1:0]})
                   && (count_r < DEPTH_C);
  assign rem_shift = {rem_r, cand_r[bit_r]};
  assign rem_diff  = rem_shift - {1'b0, p_r};
  assign rem_ge    = (rem_shift >= {1'b0, p_r});
  assign p_above_hi = $signed({2'b00, rd_data_r}) > $signed({hi_r[psoi_pkg::IN_W-1], hi_r});
  assign p_below_lo = $signed({2'b00, rd_data_r}) < $signed({lo_r[psoi_pkg::IN_W-1], lo_r});
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psoi_pkg::ST_IDLE:   if (in_valid) state_nxt = psoi_pkg::ST_INIT;
      psoi_pkg::ST_INIT:   state_nxt = psoi_pkg::ST_CAND;
      psoi_pkg::ST_CAND:   state_nxt = cand_go ? psoi_pkg::ST_RD : psoi_pkg::ST_SRD;
      psoi_pkg::ST_RD:     state_nxt = (k_r == count_r) ? psoi_pkg::ST_STORE : psoi_pkg::ST_WAIT;
      psoi_pkg::ST_WAIT:   state_nxt = psoi_pkg::ST_CMP;
      psoi_pkg::ST_CMP: begin
        if (sq_r > 32'(cand_r)) state_nxt = psoi_pkg::ST_STORE;
        else state_nxt = psoi_pkg::ST_DIV;
      end
      psoi_pkg::ST_DIV:    if (bit_r == '0) state_nxt = psoi_pkg::ST_DIVEND;
      psoi_pkg::ST_DIVEND: state_nxt = (rem_r == '0) ? psoi_pkg::ST_CAND : psoi_pkg::ST_RD;
      psoi_pkg::ST_STORE:  state_nxt = psoi_pkg::ST_CAND;
      psoi_pkg::ST_SRD:    state_nxt = (k_r == count_r) ? psoi_pkg::ST_DONE : psoi_pkg::ST_SWAIT;
      psoi_pkg::ST_SWAIT:  state_nxt = p_above_hi ? psoi_pkg::ST_DONE : psoi_pkg::ST_SRD;
      psoi_pkg::ST_DONE:   if (out_free) state_nxt = psoi_pkg::ST_IDLE;
      default:             state_nxt = psoi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = count_r[AW-1:0];
    wr_data  = cand_r[psoi_pkg::PRIME_W-1:0];
    rd_addr  = k_r[AW-1:0];
    case (state_r)
      psoi_pkg::ST_IDLE: in_ready = 1'b1;
      psoi_pkg::ST_INIT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = psoi_pkg::FIRST_PRIME;
      end
      psoi_pkg::ST_RD:    rd_en = (k_r != count_r);
      psoi_pkg::ST_SRD:   rd_en = (k_r != count_r);
      psoi_pkg::ST_STORE: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psoi_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == psoi_pkg::ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      psoi_pkg::ST_IDLE: begin
        if (in_valid) begin
          lo_r <= in_range_low;
          hi_r <= (in_range_high > MAX_HI) ? MAX_HI : in_range_high;
        end
      end
      psoi_pkg::ST_INIT: begin
        count_r <= CW'(1);
        cand_r  <= psoi_pkg::FIRST_ODD;
        sum_r   <= '0;
        k_r     <= '0;
      end
      psoi_pkg::ST_CAND: k_r <= '0;
      psoi_pkg::ST_WAIT: begin
        p_r  <= rd_data_r;
        sq_r <= rd_data_r * rd_data_r;
      end
      psoi_pkg::ST_CMP: begin
        rem_r <= '0;
        bit_r <= psoi_pkg::BIT_W'(psoi_pkg::PRIME_W - 1);
      end
      psoi_pkg::ST_DIV: begin
        rem_r <= rem_ge ? rem_diff[psoi_pkg::PRIME_W-1:0] : rem_shift[psoi_pkg::PRIME_W-1:0];
        bit_r <= bit_r - 1'b1;
      end
      psoi_pkg::ST_DIVEND: begin
        if (rem_r == '0) cand_r <= cand_r + 17'd2;
        else k_r <= k_r + 1'b1;
      end
      psoi_pkg::ST_STORE: begin
        count_r <= count_r + 1'b1;
        cand_r  <= cand_r + 17'd2;
      end
      psoi_pkg::ST_SWAIT: begin
        if (!p_above_hi) begin
          if (!p_below_lo) sum_r <= sum_r + psoi_pkg::TOTAL_W'(rd_data_r);
          k_r <= k_r + 1'b1;
        end
      end
      psoi_pkg::ST_DONE: if (out_free) out_total_r <= sum_r;
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_prime_total = out_total_r;

endmodule
`default_nettype wire

FILE: verif/prime_sum_over_interval_tb.sv
// Testbench for prime_sum_over_interval: directed and random interval queries against a trial-division model.
module prime_sum_over_interval_tb;

  localparam int unsigned IN_W          = psoi_pkg::IN_W;
  localparam int unsigned TOTAL_W       = psoi_pkg::TOTAL_W;
  localparam int          MAX_BOUND     = 65535;
  localparam int          TABLE_DEPTH   = 8192;
  localparam int          RANDOM_ITEMS  = 80;
  localparam int          DRAIN_CYCLES  = 100;
  localparam int          IDLE_PERCENT  = 12;
  localparam int          WATCHDOG_LIMIT = 250_000_000;

  typedef struct {
    logic [IN_W-1:0] low;
    logic [IN_W-1:0] high;
  } range_query_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [IN_W-1:0]     in_range_low = '0;
  logic signed [IN_W-1:0]     in_range_high = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [TOTAL_W-1:0]         out_prime_total;

  range_query_t               query_q[$];
  logic [TOTAL_W-1:0]         expected_totals[$];
  int                         queries_sent = 0;
  int                         mismatches = 0;
  int                         idle_cycles = 0;
  logic                       calm;

  prime_sum_over_interval #(
    .MAX_BOUND(MAX_BOUND),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_range_low(in_range_low),
    .in_range_high(in_range_high),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_prime_total(out_prime_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // no idling on either side while this window of transactions goes through
  assign calm = (queries_sent >= 50) && (queries_sent < 75);

  function automatic logic [TOTAL_W-1:0] interval_prime_sum(
    logic signed [IN_W-1:0] low_bound,
    logic signed [IN_W-1:0] high_bound
  );
    int          lo;
    int          hi;
    int          cand;
    int          k;
    bit          composite;
    int unsigned total;
    int          primes[$];
    lo = low_bound;
    hi = high_bound;
    if (hi > MAX_BOUND) hi = MAX_BOUND;
    total = 0;
    primes = {2};
    for (cand = 3; cand <= hi && primes.size() < TABLE_DEPTH; cand += 2) begin
      composite = 1'b0;
      for (k = 0; k < primes.size() && primes[k] * primes[k] <= cand && !composite; k++)
        composite = (cand % primes[k]) == 0;
      if (!composite) primes.push_back(cand);
    end
    foreach (primes[i])
      if (primes[i] >= lo && primes[i] <= hi) total += primes[i];
    return total[TOTAL_W-1:0];
  endfunction

  task automatic add_query(int lo, int hi);
    range_query_t q;
    q.low  = lo[IN_W-1:0];
    q.high = hi[IN_W-1:0];
    query_q.push_back(q);
  endtask

  always @(posedge clk) begin : drive_queries
    range_query_t pick;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_totals.push_back(interval_prime_sum(in_range_low, in_range_high));
        queries_sent++;
      end
      if (!in_valid || in_ready) begin
        if (query_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
          pick = query_q.pop_front();
          in_range_low  <= pick.low;
          in_range_high <= pick.high;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_totals
    logic [TOTAL_W-1:0] want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      if (out_valid && out_ready) begin
        if (expected_totals.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: prime_total=%0d", out_prime_total);
          mismatches++;
        end else begin
          want = expected_totals.pop_front();
          if (out_prime_total !== want) begin
            if (mismatches < 10)
              $display("prime_total mismatch: expected %0d, got %0d", want, out_prime_total);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : run_queries
    int lo;
    int hi;
    int kind;
    add_query(-65536, 1);
    add_query(-65536, -65536);
    add_query(0, -1);
    add_query(-1, -1);
    add_query(0, 0);
    add_query(2, 2);
    add_query(3, 3);
    add_query(-5, 3);
    add_query(-100, 2);
    add_query(4, 4);
    add_query(97, 97);
    add_query(90, 96);
    add_query(3, 2);
    add_query(100, 50);
    add_query(65535, 10);
    add_query(65535, -65536);
    add_query(-65536, 100);
    add_query(2, 1000);
    add_query(1000, 1100);
    add_query(-65536, 65535);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        hi = $urandom_range(400);
        lo = int'($urandom_range(hi + 20)) - 20;
      end else if (kind < 80) begin
        hi = $urandom_range(1500, 400);
        lo = $urandom_range(hi);
      end else if (kind < 90) begin
        hi = int'($urandom_range(65535)) - 65536;
        lo = int'($urandom_range(131071)) - 65536;
      end else begin
        hi = $urandom_range(300);
        lo = int'($urandom_range(131071)) - 65536;
      end
      add_query(lo, hi);
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (query_q.size() != 0 || in_valid || expected_totals.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_totals.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: filelist.f
design/psoi_pkg.sv
design/prime_sum_over_interval.sv
verif/prime_sum_over_interval_tb.sv
